// ===== hw/rtl/ctk_pkg.sv =====
// Package for the C source tokenizer: token and error codes, scan modes,
// character classes, result record and the keyword table.
// No dependencies; used by every module of the tokenizer.
package ctk_pkg;

  // Token codes
  localparam logic [5:0] TK_IDENT    = 6'd0;
  localparam logic [5:0] TK_STRING   = 6'd1;
  localparam logic [5:0] TK_INTEGER  = 6'd2;
  localparam logic [5:0] TK_FLOAT    = 6'd3;
  localparam logic [5:0] TK_ADD      = 6'd4;
  localparam logic [5:0] TK_SUB      = 6'd5;
  localparam logic [5:0] TK_MUL      = 6'd6;
  localparam logic [5:0] TK_AMP      = 6'd7;
  localparam logic [5:0] TK_QUEST    = 6'd8;
  localparam logic [5:0] TK_COLON    = 6'd9;
  localparam logic [5:0] TK_LAND     = 6'd10;
  localparam logic [5:0] TK_LOR      = 6'd11;
  localparam logic [5:0] TK_REL      = 6'd12;
  localparam logic [5:0] TK_EQU      = 6'd13;
  localparam logic [5:0] TK_DIV      = 6'd14;
  localparam logic [5:0] TK_BOR      = 6'd15;
  localparam logic [5:0] TK_XOR      = 6'd16;
  localparam logic [5:0] TK_SHIFT    = 6'd17;
  localparam logic [5:0] TK_INCDEC   = 6'd18;
  localparam logic [5:0] TK_NOT      = 6'd19;
  localparam logic [5:0] TK_MEMBER   = 6'd20;
  localparam logic [5:0] TK_TYPE     = 6'd21;
  localparam logic [5:0] TK_STORAGE  = 6'd22;
  localparam logic [5:0] TK_STRUCT   = 6'd23;
  localparam logic [5:0] TK_RETURN   = 6'd24;
  localparam logic [5:0] TK_GOTO     = 6'd25;
  localparam logic [5:0] TK_IF       = 6'd26;
  localparam logic [5:0] TK_ELSE     = 6'd27;
  localparam logic [5:0] TK_SWITCH   = 6'd28;
  localparam logic [5:0] TK_BREAK    = 6'd29;
  localparam logic [5:0] TK_CONTINUE = 6'd30;
  localparam logic [5:0] TK_WHILE    = 6'd31;
  localparam logic [5:0] TK_DO       = 6'd32;
  localparam logic [5:0] TK_FOR      = 6'd33;
  localparam logic [5:0] TK_DEFAULT  = 6'd34;
  localparam logic [5:0] TK_CASE     = 6'd35;
  localparam logic [5:0] TK_SIZEOF   = 6'd36;
  localparam logic [5:0] TK_LPAREN   = 6'd37;
  localparam logic [5:0] TK_RPAREN   = 6'd38;
  localparam logic [5:0] TK_LBRACE   = 6'd39;
  localparam logic [5:0] TK_RBRACE   = 6'd40;
  localparam logic [5:0] TK_LBRACK   = 6'd41;
  localparam logic [5:0] TK_RBRACK   = 6'd42;
  localparam logic [5:0] TK_COMMA    = 6'd43;
  localparam logic [5:0] TK_SEMI     = 6'd44;
  localparam logic [5:0] TK_ASSIGN   = 6'd45;
  localparam logic [5:0] TK_OPASSIGN = 6'd46;
  localparam logic [5:0] TK_HASH     = 6'd47;
  localparam logic [5:0] TK_INCLUDE  = 6'd48;
  localparam logic [5:0] TK_DEFINE   = 6'd49;
  localparam logic [5:0] TK_IFDEF    = 6'd50;
  localparam logic [5:0] TK_IFNDEF   = 6'd51;
  localparam logic [5:0] TK_ENDIF    = 6'd52;
  localparam logic [5:0] TK_BLANK    = 6'd53;

  // Error kinds
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL  = 3'd1;
  localparam logic [2:0] ERR_BAD_ID   = 3'd2;
  localparam logic [2:0] ERR_BAD_FLT  = 3'd3;
  localparam logic [2:0] ERR_BAD_INT  = 3'd4;
  localparam logic [2:0] ERR_UNTERM   = 3'd5;

  // Scan modes
  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUM, M_OP, M_SQ, M_DQ
  } mode_t;

  // Character classes
  typedef enum logic [3:0] {
    C_LETTER, C_DIGIT, C_OPER, C_DOT, C_DELIM, C_BLANK, C_SQ, C_DQ, C_ILLEGAL
  } cls_t;

  // One result item
  typedef struct packed {
    logic [5:0]  code;
    logic [2:0]  err;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } res_t;

  // Status seen by the top level for flow control and checks
  typedef struct packed {
    mode_t mode;
  } core_stat_t;

  typedef struct packed {
    logic [2:0] count;
  } fifo_stat_t;

  // Keyword table; word characters in string order, first char highest
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  len;
    logic [5:0]  code;
  } kw_entry_t;

  localparam int KW_COUNT = 33;
  localparam int KW_CHARS = 8;

  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{"auto", 4'd4, TK_STORAGE},   '{"break", 4'd5, TK_BREAK},
    '{"case", 4'd4, TK_CASE},      '{"char", 4'd4, TK_TYPE},
    '{"continue", 4'd8, TK_CONTINUE}, '{"default", 4'd7, TK_DEFAULT},
    '{"do", 4'd2, TK_DO},          '{"double", 4'd6, TK_TYPE},
    '{"else", 4'd4, TK_ELSE},      '{"extern", 4'd6, TK_STORAGE},
    '{"float", 4'd5, TK_TYPE},     '{"for", 4'd3, TK_FOR},
    '{"goto", 4'd4, TK_GOTO},      '{"if", 4'd2, TK_IF},
    '{"int", 4'd3, TK_TYPE},       '{"long", 4'd4, TK_TYPE},
    '{"register", 4'd8, TK_STORAGE}, '{"return", 4'd6, TK_RETURN},
    '{"short", 4'd5, TK_TYPE},     '{"sizeof", 4'd6, TK_SIZEOF},
    '{"static", 4'd6, TK_STORAGE}, '{"struct", 4'd6, TK_STRUCT},
    '{"switch", 4'd6, TK_SWITCH},  '{"typedef", 4'd7, TK_STORAGE},
    '{"union", 4'd5, TK_STRUCT},   '{"unsigned", 4'd8, TK_TYPE},
    '{"void", 4'd4, TK_TYPE},      '{"while", 4'd5, TK_WHILE},
    '{"include", 4'd7, TK_INCLUDE}, '{"define", 4'd6, TK_DEFINE},
    '{"ifdef", 4'd5, TK_IFDEF},    '{"ifndef", 4'd6, TK_IFNDEF},
    '{"endif", 4'd5, TK_ENDIF}
  };

  // Character classification
  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$")
      r = C_LETTER;
    else if (c >= "0" && c <= "9")
      r = C_DIGIT;
    else begin
      unique case (c)
        "+", "-", "*", "/", ":", "=", "<", ">", "?", "&", "|", "!", "%", "^", "~":
          r = C_OPER;
        ".": r = C_DOT;
        ",", ";", "(", ")", "[", "]", "{", "}", "#": r = C_DELIM;
        8'h09, 8'h20, 8'h0A: r = C_BLANK;
        8'h27: r = C_SQ;
        8'h22: r = C_DQ;
        default: r = C_ILLEGAL;
      endcase
    end
    return r;
  endfunction

  // Code of a lone operator or delimiter
  function automatic logic [5:0] single_code(input logic [7:0] c);
    logic [5:0] r;
    unique case (c)
      "=": r = TK_ASSIGN;   ";": r = TK_SEMI;    ",": r = TK_COMMA;
      "]": r = TK_RBRACK;   "[": r = TK_LBRACK;  "}": r = TK_RBRACE;
      "{": r = TK_LBRACE;   ")": r = TK_RPAREN;  "(": r = TK_LPAREN;
      ".": r = TK_MEMBER;   "!", "~": r = TK_NOT; "^": r = TK_XOR;
      "|": r = TK_BOR;      "/", "%": r = TK_DIV; ">", "<": r = TK_REL;
      ":": r = TK_COLON;    "?": r = TK_QUEST;   "&": r = TK_AMP;
      "*": r = TK_MUL;      "-": r = TK_SUB;     "+": r = TK_ADD;
      "#": r = TK_HASH;
      default: r = TK_IDENT;
    endcase
    return r;
  endfunction

  // Code of a two-character operator; TK_IDENT when the pair does not join
  function automatic logic [5:0] pair_code(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] r;
    priority if (a == "&" && b == "&") r = TK_LAND;
    else if (a == "|" && b == "|") r = TK_LOR;
    else if ((a == ">" || a == "<") && b == "=") r = TK_REL;
    else if ((a == "=" || a == "!") && b == "=") r = TK_EQU;
    else if ((a == "<" && b == "<") || (a == ">" && b == ">")) r = TK_SHIFT;
    else if ((a == "+" && b == "+") || (a == "-" && b == "-")) r = TK_INCDEC;
    else if (a == "-" && b == ">") r = TK_MEMBER;
    else if (b == "=" && (a == "+" || a == "-" || a == "*" || a == "/" || a == "%" ||
                          a == "^" || a == "&" || a == "|")) r = TK_OPASSIGN;
    else r = TK_IDENT;
    return r;
  endfunction

endpackage

// ===== hw/rtl/ctk_kwmatch.sv =====
// Keyword matcher: compares the buffered identifier head against every
// keyword in parallel. Depends on ctk_pkg.
module ctk_kwmatch #(
  parameter int LENGTH_BITS = 16
) (
  input  logic [63:0]            head,    // char j at bits 8j+7:8j
  input  logic [LENGTH_BITS-1:0] len,
  output logic [5:0]             code
);
  import ctk_pkg::*;

  // One compare per table entry; at most one entry can hit
  always_comb begin
    logic hit;
    int   sh;
    code = TK_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (len == LENGTH_BITS'(KW_TABLE[i].len));
      for (int j = 0; j < KW_CHARS; j++) begin
        sh = 8 * (int'(KW_TABLE[i].len) - 1 - j);
        if (j < int'(KW_TABLE[i].len))
          hit = hit && (head[8*j +: 8] == KW_TABLE[i].word[sh +: 8]);
      end
      if (hit) code = KW_TABLE[i].code;
    end
  end

endmodule

// ===== hw/rtl/ctk_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle and
// hands out one. Depends on ctk_pkg.
module ctk_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  ctk_pkg::res_t       d0,
  input  ctk_pkg::res_t       d1,
  input  logic                pop,
  output ctk_pkg::res_t       q,
  output logic                not_empty,
  output ctk_pkg::fifo_stat_t stat
);
  import ctk_pkg::*;

  res_t       mem_r [4];
  logic [1:0] wr_r, rd_r, wr_nxt, rd_nxt;
  logic [2:0] count_r, count_nxt;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_nxt    = wr_r + push_n;
    rd_nxt    = rd_r + 2'(pop);
    count_nxt = count_r + 3'(push_n) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_r] <= d0;
    if (push_n == 2'd2) mem_r[wr_r + 2'd1] <= d1;
  end

  assign q          = mem_r[rd_r];
  assign not_empty  = (count_r != 3'd0);
  assign stat.count = count_r;

endmodule

// ===== hw/rtl/ctk_core.sv =====
// Tokenizer scan state and the single-pass step for one character item.
// Depends on ctk_pkg and ctk_kwmatch.
module ctk_core #(
  parameter int MATCH_CHARS   = 8,
  parameter int LENGTH_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,       // item accepted this cycle
  input  logic [7:0]          ch,
  input  logic                eoi,
  output logic [1:0]          push_n,
  output ctk_pkg::res_t       r0,
  output ctk_pkg::res_t       r1,
  output ctk_pkg::core_stat_t stat
);
  import ctk_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  mode_t                    mode_r, mode_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt, len_inc;
  logic [POSITION_BITS-1:0] tstart_r, tstart_nxt, pos_r, pos_nxt;
  logic                     fdot_r, fexp_r, ferr_r, fdot_nxt, fexp_nxt, ferr_nxt;
  logic [7:0]               prev_r, prev_nxt;
  logic [7:0]               head_r [MATCH_CHARS];
  logic [63:0]              head_pk;
  logic [5:0]               kw_code;
  logic                     hw_grow, hw_first;

  logic       a_v, b_v, done, isf, numerr;
  logic [5:0] a_code, b_code, pc;
  logic [2:0] a_err, b_err;
  logic [LENGTH_BITS-1:0] a_len;
  cls_t       cls;

  for (genvar g = 0; g < KW_CHARS; g++) begin : g_head
    assign head_pk[8*g +: 8] = head_r[g];
  end

  ctk_kwmatch #(.LENGTH_BITS(LENGTH_BITS)) u_kw (
    .head (head_pk),
    .len  (len_r),
    .code (kw_code)
  );

  // Saturating length clamp to the 16-bit result field
  function automatic logic [15:0] sat16(input logic [LENGTH_BITS-1:0] v);
    logic [15:0] r;
    if (LENGTH_BITS > 16 && (v >> 16) != '0) r = 16'hFFFF;
    else r = 16'(v);
    return r;
  endfunction

  // Step logic: flush or extend the pending token, then start a new one
  always_comb begin
    cls        = classify(ch);
    len_inc    = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
    isf        = fdot_r || fexp_r;
    numerr     = 1'b0;
    pc         = TK_IDENT;
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    tstart_nxt = tstart_r;
    pos_nxt    = pos_r + 1'b1;
    fdot_nxt   = fdot_r;
    fexp_nxt   = fexp_r;
    ferr_nxt   = ferr_r;
    prev_nxt   = ch;
    hw_grow    = 1'b0;
    hw_first   = 1'b0;
    a_v        = 1'b0;
    a_code     = TK_IDENT;
    a_err      = ERR_NONE;
    a_len      = len_r;
    b_v        = 1'b0;
    b_code     = TK_IDENT;
    b_err      = ERR_NONE;
    done       = 1'b0;

    if (eoi) begin
      // End of input: flush whatever is pending and restart the stream
      a_v = (mode_r != M_IDLE);
      unique case (mode_r)
        M_IDENT: a_code = kw_code;
        M_NUM: begin
          a_code = isf ? TK_FLOAT : TK_INTEGER;
          a_err  = ferr_r ? (isf ? ERR_BAD_FLT : ERR_BAD_INT) : ERR_NONE;
        end
        M_OP: a_code = single_code(head_r[0]);
        M_SQ: begin a_code = TK_INTEGER; a_err = ERR_UNTERM; end
        M_DQ: begin a_code = TK_STRING; a_err = ERR_UNTERM; end
        default: a_v = 1'b0;
      endcase
      mode_nxt = M_IDLE;
      len_nxt  = '0;
      fdot_nxt = 1'b0;
      fexp_nxt = 1'b0;
      ferr_nxt = 1'b0;
      pos_nxt  = '0;
      prev_nxt = 8'd0;
      done     = 1'b1;
    end else begin
      unique case (mode_r)
        M_IDENT: begin
          if (cls == C_LETTER || cls == C_DIGIT) begin
            hw_grow = 1'b1;
            len_nxt = len_inc;
            done    = 1'b1;
          end else begin
            a_v    = 1'b1;
            a_code = (cls == C_ILLEGAL) ? TK_IDENT : kw_code;
            a_err  = (cls == C_ILLEGAL) ? ERR_BAD_ID : ERR_NONE;
          end
        end
        M_NUM: begin
          if (cls == C_DIGIT) begin
            len_nxt = len_inc;
            done    = 1'b1;
          end else if (cls == C_DOT) begin
            ferr_nxt = ferr_r || fdot_r;
            fdot_nxt = 1'b1;
            len_nxt  = len_inc;
            done     = 1'b1;
          end else if (ch == "e" || ch == "E") begin
            ferr_nxt = ferr_r || fexp_r;
            fexp_nxt = 1'b1;
            len_nxt  = len_inc;
            done     = 1'b1;
          end else begin
            numerr = ferr_r || !(cls == C_OPER || cls == C_DELIM || cls == C_BLANK);
            a_v    = 1'b1;
            a_code = isf ? TK_FLOAT : TK_INTEGER;
            a_err  = numerr ? (isf ? ERR_BAD_FLT : ERR_BAD_INT) : ERR_NONE;
          end
        end
        M_OP: begin
          pc  = (cls == C_OPER) ? pair_code(head_r[0], ch) : TK_IDENT;
          a_v = 1'b1;
          if (pc != TK_IDENT) begin
            a_code   = pc;
            a_len    = LENGTH_BITS'(2);
            mode_nxt = M_IDLE;
            len_nxt  = '0;
            done     = 1'b1;
          end else begin
            a_code = single_code(head_r[0]);
          end
        end
        M_SQ, M_DQ: begin
          done    = 1'b1;
          len_nxt = len_inc;
          // A quote of the same kind closes unless escaped
          if (((mode_r == M_SQ && cls == C_SQ) || (mode_r == M_DQ && cls == C_DQ)) &&
              prev_r != 8'h5C) begin
            a_v      = 1'b1;
            a_code   = (mode_r == M_SQ) ? TK_INTEGER : TK_STRING;
            a_len    = len_inc;
            mode_nxt = M_IDLE;
            len_nxt  = '0;
          end
        end
        default: ;
      endcase

      // The character opens a new token
      if (!done) begin
        tstart_nxt = pos_r;
        len_nxt    = LENGTH_BITS'(1);
        fdot_nxt   = 1'b0;
        fexp_nxt   = 1'b0;
        ferr_nxt   = 1'b0;
        mode_nxt   = M_IDLE;
        unique case (cls)
          C_LETTER: begin mode_nxt = M_IDENT; hw_first = 1'b1; end
          C_DIGIT: mode_nxt = M_NUM;
          C_OPER, C_DOT: begin mode_nxt = M_OP; hw_first = 1'b1; end
          C_DELIM: begin b_v = 1'b1; b_code = single_code(ch); end
          C_BLANK: begin b_v = 1'b1; b_code = TK_BLANK; end
          C_SQ: mode_nxt = M_SQ;
          C_DQ: mode_nxt = M_DQ;
          default: begin b_v = 1'b1; b_code = TK_IDENT; b_err = ERR_ILLEGAL; end
        endcase
      end
    end
  end

  // Pack the results in order into the two queue write slots
  always_comb begin
    res_t ra, rb;
    ra.code  = a_code;
    ra.err   = a_err;
    ra.start = 32'(tstart_r);
    ra.len   = sat16(a_len);
    ra.last  = !b_v;
    rb.code  = b_code;
    rb.err   = b_err;
    rb.start = 32'(pos_r);
    rb.len   = 16'd1;
    rb.last  = 1'b1;
    r0       = a_v ? ra : rb;
    r1       = rb;
    push_n   = step ? (2'(a_v) + 2'(b_v)) : 2'd0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      len_r    <= '0;
      tstart_r <= '0;
      pos_r    <= '0;
      fdot_r   <= 1'b0;
      fexp_r   <= 1'b0;
      ferr_r   <= 1'b0;
      prev_r   <= 8'd0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      len_r    <= len_nxt;
      tstart_r <= tstart_nxt;
      pos_r    <= pos_nxt;
      fdot_r   <= fdot_nxt;
      fexp_r   <= fexp_nxt;
      ferr_r   <= ferr_nxt;
      prev_r   <= prev_nxt;
    end
  end

  // Identifier head characters
  always_ff @(posedge clk) begin
    if (step && !eoi) begin
      for (int i = 0; i < MATCH_CHARS; i++) begin
        if ((hw_grow && len_r == LENGTH_BITS'(i)) || (hw_first && i == 0))
          head_r[i] <= ch;
      end
    end
  end

  assign stat.mode = mode_r;

endmodule

// ===== hw/rtl/c_source_tokenizer.sv =====
// C source tokenizer top level: one character item in, C token items out.
// A result is registered into the result queue with the item that closes it.
// Throughput: one item per cycle while items give at most one result and the
// output is not stalled; input stalls while the queue holds more than two.
// Reset: synchronous active-low rst_n clears scan state, position and queue.
// Depends on ctk_pkg, ctk_core, ctk_kwmatch and ctk_fifo.
module c_source_tokenizer #(
  parameter int MATCH_CHARS   = 8,
  parameter int LENGTH_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic [0:0]  in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [5:0] token_code, [8:6] error_kind,
                                  // [40:9] start_position, [56:41] token_length
  output logic        out_tlast
);
  import ctk_pkg::*;

  logic       step, pop;
  logic [1:0] push_n;
  res_t       r0, r1, q;
  core_stat_t cstat;
  fifo_stat_t fstat;

  // Accept an item only while the queue has room for two results
  assign in_tready = (fstat.count <= 3'd2);
  assign step      = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  ctk_core #(
    .MATCH_CHARS  (MATCH_CHARS),
    .LENGTH_BITS  (LENGTH_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .ch     (in_tdata),
    .eoi    (in_tuser[0]),
    .push_n (push_n),
    .r0     (r0),
    .r1     (r1),
    .stat   (cstat)
  );

  ctk_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .d0        (r0),
    .d1        (r1),
    .pop       (pop),
    .q         (q),
    .not_empty (out_tvalid),
    .stat      (fstat)
  );

  // Output packing
  assign out_tdata = {7'd0, q.len, q.start, q.err, q.code};
  assign out_tlast = q.last;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.count <= 3'd4) else $error("result queue overfilled");

  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_tuser[0]) |=> (cstat.mode == M_IDLE))
    else $error("scan not idle after end of input");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result offered after reset");

endmodule

// ===== tb/tb_c_source_tokenizer.sv =====
// Self-checking testbench for the C source tokenizer: drives character items,
// predicts tokens with its own scanner model and checks every result item.
// Depends on ctk_pkg and the c_source_tokenizer top level.
`timescale 1ns / 100ps

module tb_c_source_tokenizer;
  import ctk_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic       eoi;
    logic [7:0] ch;
  } char_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tlast;

  c_source_tokenizer uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  char_item_t pending_chars[$];
  res_t       expected_tokens[$];
  int         fail_count;
  int         quiet_cycles;
  bit         stimulus_done;
  bit         no_idle;

  // Scanner state of the prediction.
  mode_t       sc_mode;
  logic [7:0]  sc_head[8];
  logic [15:0] sc_len;
  logic [31:0] sc_start;
  logic [31:0] sc_pos;
  logic [2:0]  sc_flags;   // bit0 dot, bit1 exponent, bit2 error
  logic [7:0]  sc_prev;

  function automatic cls_t char_class(input logic [7:0] c);
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$")
      return C_LETTER;
    if (c >= "0" && c <= "9") return C_DIGIT;
    case (c)
      "+", "-", "*", "/", ":", "=", "<", ">", "?", "&", "|", "!", "%", "^", "~":
        return C_OPER;
      ".": return C_DOT;
      ",", ";", "(", ")", "[", "]", "{", "}", "#": return C_DELIM;
      8'h09, 8'h20, 8'h0A: return C_BLANK;
      8'h27: return C_SQ;
      8'h22: return C_DQ;
      default: return C_ILLEGAL;
    endcase
  endfunction

  function automatic logic [5:0] lone_op_code(input logic [7:0] c);
    case (c)
      "=": return TK_ASSIGN;  ";": return TK_SEMI;   ",": return TK_COMMA;
      "]": return TK_RBRACK;  "[": return TK_LBRACK; "}": return TK_RBRACE;
      "{": return TK_LBRACE;  ")": return TK_RPAREN; "(": return TK_LPAREN;
      ".": return TK_MEMBER;  "!", "~": return TK_NOT; "^": return TK_XOR;
      "|": return TK_BOR;     "/", "%": return TK_DIV; ">", "<": return TK_REL;
      ":": return TK_COLON;   "?": return TK_QUEST;  "&": return TK_AMP;
      "*": return TK_MUL;     "-": return TK_SUB;    "+": return TK_ADD;
      "#": return TK_HASH;
      default: return TK_IDENT;
    endcase
  endfunction

  // Two-character operators; TK_IDENT means the pair does not join.
  function automatic logic [5:0] joined_op_code(input logic [7:0] a, input logic [7:0] b);
    if (a == "&" && b == "&") return TK_LAND;
    if (a == "|" && b == "|") return TK_LOR;
    if ((a == ">" || a == "<") && b == "=") return TK_REL;
    if ((a == "=" || a == "!") && b == "=") return TK_EQU;
    if ((a == "<" && b == "<") || (a == ">" && b == ">")) return TK_SHIFT;
    if ((a == "+" && b == "+") || (a == "-" && b == "-")) return TK_INCDEC;
    if (a == "-" && b == ">") return TK_MEMBER;
    if (b == "=" && (a == "+" || a == "-" || a == "*" || a == "/" || a == "%" ||
                     a == "^" || a == "&" || a == "|")) return TK_OPASSIGN;
    return TK_IDENT;
  endfunction

  // Keyword lookup on exact length and characters of the identifier head.
  function automatic logic [5:0] word_code();
    logic [63:0] w;
    int          n;
    for (int i = 0; i < KW_COUNT; i++) begin
      w = KW_TABLE[i].word;
      n = KW_TABLE[i].len;
      if (sc_len == n) begin
        bit ok;
        ok = 1'b1;
        for (int j = 0; j < n; j++)
          if (sc_head[j] != w[8*(n-1-j) +: 8]) ok = 1'b0;
        if (ok) return KW_TABLE[i].code;
      end
    end
    return TK_IDENT;
  endfunction

  function automatic void push_token(input logic [5:0] code, input logic [2:0] err,
                                     input logic [31:0] start, input logic [15:0] len);
    res_t r;
    r.code = code; r.err = err; r.start = start; r.len = len; r.last = 1'b0;
    expected_tokens.push_back(r);
  endfunction

  function automatic void push_number();
    bit isf;
    isf = (sc_flags[1:0] != 2'b00);
    push_token(isf ? TK_FLOAT : TK_INTEGER,
               sc_flags[2] ? (isf ? ERR_BAD_FLT : ERR_BAD_INT) : ERR_NONE, sc_start, sc_len);
  endfunction

  function automatic void lengthen();
    if (sc_len != 16'hFFFF) sc_len++;
  endfunction

  // Works out the tokens of one accepted character item.
  function automatic void scan_char(input char_item_t it);
    int          prior_count;
    cls_t        cl;
    logic [31:0] pos;
    logic [5:0]  pc;
    bit          taken;
    prior_count = expected_tokens.size();
    taken = 1'b0;
    if (it.eoi) begin
      case (sc_mode)
        M_IDENT: push_token(word_code(), ERR_NONE, sc_start, sc_len);
        M_NUM:   push_number();
        M_OP:    push_token(lone_op_code(sc_head[0]), ERR_NONE, sc_start, sc_len);
        M_SQ:    push_token(TK_INTEGER, ERR_UNTERM, sc_start, sc_len);
        M_DQ:    push_token(TK_STRING, ERR_UNTERM, sc_start, sc_len);
        default: ;
      endcase
      sc_mode = M_IDLE; sc_len = 0; sc_flags = 0; sc_pos = 0; sc_prev = 0;
    end else begin
      cl = char_class(it.ch);
      pos = sc_pos;
      sc_pos = sc_pos + 1;
      case (sc_mode)
        M_IDENT: begin
          if (cl == C_LETTER || cl == C_DIGIT) begin
            if (sc_len < 8) sc_head[sc_len[2:0]] = it.ch;
            lengthen();
            taken = 1'b1;
          end else if (cl == C_ILLEGAL) begin
            push_token(TK_IDENT, ERR_BAD_ID, sc_start, sc_len);
          end else begin
            push_token(word_code(), ERR_NONE, sc_start, sc_len);
          end
        end
        M_NUM: begin
          if (cl == C_DIGIT) begin
            lengthen(); taken = 1'b1;
          end else if (cl == C_DOT) begin
            if (sc_flags[0]) sc_flags[2] = 1'b1;
            sc_flags[0] = 1'b1; lengthen(); taken = 1'b1;
          end else if (it.ch == "e" || it.ch == "E") begin
            if (sc_flags[1]) sc_flags[2] = 1'b1;
            sc_flags[1] = 1'b1; lengthen(); taken = 1'b1;
          end else begin
            if (!(cl == C_OPER || cl == C_DELIM || cl == C_BLANK)) sc_flags[2] = 1'b1;
            push_number();
          end
        end
        M_OP: begin
          pc = (cl == C_OPER) ? joined_op_code(sc_head[0], it.ch) : TK_IDENT;
          if (pc != TK_IDENT) begin
            push_token(pc, ERR_NONE, sc_start, 16'd2);
            sc_mode = M_IDLE; sc_len = 0; taken = 1'b1;
          end else begin
            push_token(lone_op_code(sc_head[0]), ERR_NONE, sc_start, sc_len);
          end
        end
        M_SQ, M_DQ: begin
          lengthen();
          if (((sc_mode == M_SQ && cl == C_SQ) || (sc_mode == M_DQ && cl == C_DQ)) &&
              sc_prev != 8'h5C) begin
            push_token(sc_mode == M_SQ ? TK_INTEGER : TK_STRING, ERR_NONE, sc_start, sc_len);
            sc_mode = M_IDLE; sc_len = 0;
          end
          taken = 1'b1;
        end
        default: ;
      endcase
      // The closing character opens the next token.
      if (!taken) begin
        sc_mode = M_IDLE; sc_start = pos; sc_len = 1; sc_flags = 0;
        case (cl)
          C_LETTER: begin sc_mode = M_IDENT; sc_head[0] = it.ch; end
          C_DIGIT: sc_mode = M_NUM;
          C_OPER, C_DOT: begin sc_mode = M_OP; sc_head[0] = it.ch; end
          C_DELIM: push_token(lone_op_code(it.ch), ERR_NONE, pos, 16'd1);
          C_BLANK: push_token(TK_BLANK, ERR_NONE, pos, 16'd1);
          C_SQ: sc_mode = M_SQ;
          C_DQ: sc_mode = M_DQ;
          default: push_token(TK_IDENT, ERR_ILLEGAL, pos, 16'd1);
        endcase
      end
      sc_prev = it.ch;
    end
    if (expected_tokens.size() > prior_count)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  // Stimulus helpers.
  function automatic void add_char(input logic [7:0] c);
    char_item_t it;
    it.eoi = 1'b0; it.ch = c;
    pending_chars.push_back(it);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void add_end();
    char_item_t it;
    it.eoi = 1'b1; it.ch = 8'($urandom_range(0, 255));
    pending_chars.push_back(it);
  endfunction

  function automatic string pick_fragment();
    string kws[$];
    string ops[$];
    kws = '{"auto", "break", "case", "char", "continue", "default", "do", "double",
            "else", "eles", "extern", "float", "for", "goto", "if", "int", "long",
            "register", "return", "short", "sizeof", "static", "struct", "switch",
            "typedef", "union", "unsigned", "void", "while", "include", "define",
            "ifdef", "ifndef", "endif", "registers", "x_1$", "Elsewhere"};
    ops = '{"->", "&&", "||", "<=", ">=", "==", "!=", "<<", ">>", "++", "--", "+=",
            "-=", "*=", "/=", "%=", "^=", "|=", "&=", "..", "-<", "=", "?", ":", "~",
            "(", ")", "[", "]", "{", "}", ";", ",", "#", ".", "!", "&", "|"};
    case ($urandom_range(0, 7))
      0, 1: return kws[$urandom_range(0, kws.size() - 1)];
      2: return ops[$urandom_range(0, ops.size() - 1)];
      3: begin
        string s;
        string digits;
        int    cnt;
        int    k;
        s = "";
        digits = "0123456789.eE.5";
        cnt = $urandom_range(1, 5);
        for (int i = 0; i < cnt; i++) begin
          k = $urandom_range(0, 14);
          s = {s, digits.substr(k, k)};
        end
        return s;
      end
      4: return ($urandom_range(0, 1)) ? "\"a\\\"b\"" : "'\\''";
      5: return ($urandom_range(0, 1)) ? " " : "\n";
      default: return "\t";
    endcase
  endfunction

  initial begin
    int n;
    fail_count = 0;
    stimulus_done = 1'b0;
    sc_mode = M_IDLE; sc_len = 0; sc_start = 0; sc_pos = 0; sc_flags = 0; sc_prev = 0;
    for (int i = 0; i < 8; i++) sc_head[i] = 8'h00;

    // Directed part: a keyword, the misspelled else, identifiers, operators, numbers, literals, illegal bytes, ends.
    add_text("else eles x->y a-b 1.2.3e5e 12a 0x\"q\\\"\"");
    add_char(8'hFF);
    add_char(8'h00);
    add_text("#'c'\"open");
    add_end();
    add_end();

    // Random part: mostly well-formed fragments, some raw bytes and early ends.
    n = pending_chars.size();
    while (n < 900) begin
      case ($urandom_range(0, 19))
        0: add_char(8'($urandom_range(0, 255)));
        1: add_end();
        default: add_text(pick_fragment());
      endcase
      n = pending_chars.size();
    end
    add_end();
  end

  // Driver: one character item per handshake, random idle cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tuser  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        scan_char(char_item_t'({in_tuser[0], in_tdata}));
        void'(pending_chars.pop_front());
      end
      if (pending_chars.size() > 0 &&
          (no_idle || $urandom_range(0, 99) >= 31)) begin
        char_item_t nx;
        nx = pending_chars[0];
        in_tvalid <= 1'b1;
        in_tdata  <= nx.ch;
        in_tuser  <= nx.eoi;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compares every result item with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        res_t got;
        res_t want;
        got.code = out_tdata[5:0]; got.err = out_tdata[8:6];
        got.start = out_tdata[40:9]; got.len = out_tdata[56:41]; got.last = out_tlast;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token, actual %p", $time, got);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (got != want) begin
            $display("%0t: token mismatch, expected %p, actual %p", $time, want, got);
            fail_count++;
          end
        end
      end
      out_tready <= no_idle || ($urandom_range(0, 99) >= 31);
    end
  end

  // Long stretch with no idling on either side, in the middle of the stimulus.
  always @(posedge clk)
    no_idle <= (pending_chars.size() >= 400 && pending_chars.size() < 550);

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rst_n = 1'b0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while ((pending_chars.size() != 0 || expected_tokens.size() != 0 || in_tvalid) &&
           quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      if (fail_count == 0 && expected_tokens.size() == 0)
        $display("tb: success");
      else
        $display("tb: failure");
      $finish;
    end
  end

endmodule
